FILE: sv/ipv_pkg.sv
`timescale 1ns / 1ps

package ipv_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] path_byte;
    } ipv_in_t;

    typedef struct packed {
        logic       valid_res;
        logic [3:0] status;
    } ipv_out_t;

    typedef struct packed {
        logic       bytes_seen;
        logic [1:0] cont_pend;
        logic [2:0] next_rule;
        logic       utf8_failed;
        logic [2:0] char_fault;
        logic       starts_slash;
        logic [1:0] comp_len;
        logic       comp_all_dots;
        logic [1:0] comp_fault;
    } ipv_state_t;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_EMPTY      = 4'd1;
    localparam logic [3:0] ST_UTF8       = 4'd2;
    localparam logic [3:0] ST_COLON      = 4'd3;
    localparam logic [3:0] ST_BACKSLASH  = 4'd4;
    localparam logic [3:0] ST_QUOTE      = 4'd5;
    localparam logic [3:0] ST_CONTROL    = 4'd6;
    localparam logic [3:0] ST_LEAD_SLASH = 4'd7;

    localparam logic [2:0] CF_NONE      = 3'd0;
    localparam logic [2:0] CF_COLON     = 3'd3;
    localparam logic [2:0] CF_BACKSLASH = 3'd4;
    localparam logic [2:0] CF_QUOTE     = 3'd5;
    localparam logic [2:0] CF_CONTROL   = 3'd6;

    localparam logic [1:0] CMP_NONE   = 2'd0;
    localparam logic [1:0] CMP_EMPTY  = 2'd1;
    localparam logic [1:0] CMP_DOT    = 2'd2;
    localparam logic [1:0] CMP_DOTDOT = 2'd3;

    localparam logic [2:0] RULE_80_BF = 3'd0;
    localparam logic [2:0] RULE_A0_BF = 3'd1;
    localparam logic [2:0] RULE_80_9F = 3'd2;
    localparam logic [2:0] RULE_90_BF = 3'd3;
    localparam logic [2:0] RULE_80_8F = 3'd4;

    localparam ipv_state_t STATE_RST = '{
        bytes_seen:    1'b0,
        cont_pend:     2'd0,
        next_rule:     RULE_80_BF,
        utf8_failed:   1'b0,
        char_fault:    CF_NONE,
        starts_slash:  1'b0,
        comp_len:      2'd0,
        comp_all_dots: 1'b1,
        comp_fault:    CMP_NONE
    };

endpackage

FILE: sv/ipv_step.sv
`timescale 1ns / 1ps

module ipv_step (
    input  ipv_pkg::ipv_state_t state,
    input  ipv_pkg::ipv_in_t    req,
    output ipv_pkg::ipv_state_t state_next,
    output ipv_pkg::ipv_out_t   verdict
);
    import ipv_pkg::*;

    logic [7:0] b;
    logic       cont_ok;
    logic [2:0] cf;
    logic [1:0] close_f;
    logic [1:0] end_fault;
    logic [3:0] st;

    assign b = req.path_byte;

    always_comb begin
        case (state.next_rule)
            RULE_A0_BF: cont_ok = (b >= 8'hA0) && (b <= 8'hBF);
            RULE_80_9F: cont_ok = (b >= 8'h80) && (b <= 8'h9F);
            RULE_90_BF: cont_ok = (b >= 8'h90) && (b <= 8'hBF);
            RULE_80_8F: cont_ok = (b >= 8'h80) && (b <= 8'h8F);
            default:    cont_ok = (b >= 8'h80) && (b <= 8'hBF);
        endcase
    end

    always_comb begin
        if (b == 8'h3A) begin
            cf = CF_COLON;
        end else if (b == 8'h5C) begin
            cf = CF_BACKSLASH;
        end else if (b == 8'h22 || b == 8'h27) begin
            cf = CF_QUOTE;
        end else if (b < 8'h20 || b == 8'h7F) begin
            cf = CF_CONTROL;
        end else begin
            cf = CF_NONE;
        end
    end

    always_comb begin
        if (state.comp_len == 2'd0) begin
            close_f = CMP_EMPTY;
        end else if (state.comp_all_dots && state.comp_len == 2'd1) begin
            close_f = CMP_DOT;
        end else if (state.comp_all_dots && state.comp_len == 2'd2) begin
            close_f = CMP_DOTDOT;
        end else begin
            close_f = CMP_NONE;
        end
    end

    assign end_fault = (state.comp_fault != CMP_NONE) ? state.comp_fault : close_f;

    always_comb begin
        if (!state.bytes_seen) begin
            st = ST_EMPTY;
        end else if (state.utf8_failed || state.cont_pend != 2'd0) begin
            st = ST_UTF8;
        end else if (state.char_fault != CF_NONE) begin
            st = {1'b0, state.char_fault};
        end else if (state.starts_slash) begin
            st = ST_LEAD_SLASH;
        end else if (end_fault == CMP_NONE) begin
            st = ST_OK;
        end else begin
            st = ST_LEAD_SLASH + {2'b00, end_fault};
        end
    end

    assign verdict.valid_res = (st == ST_OK);
    assign verdict.status    = st;

    always_comb begin
        state_next = state;
        if (req.action == ACT_END) begin
            state_next = STATE_RST;
        end else begin
            if (!state.bytes_seen) begin
                state_next.starts_slash = (b == 8'h2F);
            end
            state_next.bytes_seen = 1'b1;

            if (!state.utf8_failed) begin
                if (state.cont_pend != 2'd0) begin
                    if (!cont_ok) begin
                        state_next.utf8_failed = 1'b1;
                        state_next.cont_pend   = 2'd0;
                    end else begin
                        state_next.cont_pend = state.cont_pend - 2'd1;
                    end
                    state_next.next_rule = RULE_80_BF;
                end else if (b <= 8'h7F) begin
                    state_next.cont_pend = 2'd0;
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    state_next.cont_pend = 2'd1;
                    state_next.next_rule = RULE_80_BF;
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    state_next.cont_pend = 2'd2;
                    state_next.next_rule = (b == 8'hE0) ? RULE_A0_BF :
                                           (b == 8'hED) ? RULE_80_9F : RULE_80_BF;
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    state_next.cont_pend = 2'd3;
                    state_next.next_rule = (b == 8'hF0) ? RULE_90_BF :
                                           (b == 8'hF4) ? RULE_80_8F : RULE_80_BF;
                end else begin
                    state_next.utf8_failed = 1'b1;
                end
            end

            if (state.char_fault == CF_NONE) begin
                state_next.char_fault = cf;
            end

            if (b == 8'h2F) begin
                if (state.comp_fault == CMP_NONE) begin
                    state_next.comp_fault = close_f;
                end
                state_next.comp_len      = 2'd0;
                state_next.comp_all_dots = 1'b1;
            end else begin
                if (state.comp_len != 2'd3) begin
                    state_next.comp_len = state.comp_len + 2'd1;
                end
                if (b != 8'h2E) begin
                    state_next.comp_all_dots = 1'b0;
                end
            end
        end
    end

endmodule

FILE: sv/import_path_utf8_validator_top.sv
`timescale 1ns / 1ps

// Streaming import-path checker. Send the path one byte per request (action 0),
// then one end request (action 1); the end request yields exactly one verdict,
// byte requests yield none, and the state clears for the next path. Throughput
// is one request per cycle, set by the combinational update of the running
// path state; an accepted end request is registered at the input, and its
// verdict at the output. Byte requests keep flowing while a verdict waits on
// m_ready; only a second end request stalls until the output register is free.
module import_path_utf8_validator_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ipv_pkg::ipv_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ipv_pkg::ipv_out_t m_data
);
    import ipv_pkg::*;

    logic       in_valid_reg;
    ipv_in_t    in_reg;
    ipv_state_t state_reg;
    ipv_state_t state_next;
    ipv_out_t   verdict;
    logic       m_valid_reg;
    ipv_out_t   m_data_reg;
    logic       out_free;
    logic       advance;
    logic       fire;
    logic       fire_end;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = !in_valid_reg || (in_reg.action == ACT_BYTE) || out_free;
    assign fire     = in_valid_reg && advance;
    assign fire_end = fire && (in_reg.action == ACT_END);
    assign s_ready  = advance;

    ipv_step u_step (
        .state      (state_reg),
        .req        (in_reg),
        .state_next (state_next),
        .verdict    (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_valid) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RST;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_end) begin
            m_data_reg <= verdict;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_verdict_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.valid_res == (m_data_reg.status == ST_OK)))
        else $error("valid_res disagrees with status");

    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_end |=> (state_reg == STATE_RST))
        else $error("path state not cleared after end request");

    a_verdict_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(fire_end))
        else $error("verdict raised without an end request");

    a_pending_not_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.cont_pend != 2'd0) |-> !state_reg.utf8_failed)
        else $error("continuations pending after UTF-8 failure");

    a_fresh_path_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.bytes_seen |-> (state_reg == STATE_RST))
        else $error("state dirty before first byte");

endmodule
